[rtl/mtfkc_pkg.sv]
package mtfkc_pkg;

    localparam int ENTRIES = 8;

    typedef enum logic [1:0] {
        CMD_CHECK = 2'd0,
        CMD_USE   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_key;

    // One token walks down the chain of cells per item.
    typedef struct packed {
        logic       valid;
        logic [1:0] cmd;
        logic       found;
        t_key       carry;
    } t_tok;

endpackage

[rtl/move_to_front_key_cache_top.sv]
// An accepted beat is loaded into the token register, walks the chain of ENTRIES key
// cells, one cell per cycle, and its result is then loaded into the output register.
// A new item is taken only after the last one's result has been loaded (o_in_stall).
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous and active low: all keys become zero, the chain and the
// output are emptied.
module move_to_front_key_cache_top
    import mtfkc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_key_high,
    input  logic [63:0] i_key_low,
    input  logic [31:0] i_seg_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [31:0] o_bonus
);

    t_state r_state, n_state;
    t_tok   r_tok0;
    t_key   r_key;
    logic [1:0]  r_cmd;
    logic [31:0] r_len;
    logic        r_found;
    logic        r_out_valid;
    logic        r_hit;
    logic [31:0] r_bonus;
    logic        w_accept;
    logic        w_load_out;

    t_tok w_tok [ENTRIES+1];
    logic [ENTRIES:0] w_tok_v;

    assign w_tok[0] = r_tok0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            mtfkc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[g]),
                .i_key   (r_key),
                .o_tok   (w_tok[g+1])
            );
        end
        for (g = 0; g <= ENTRIES; g++) begin : g_tv
            assign w_tok_v[g] = w_tok[g].valid;
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        w_accept   = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_accept = 1'b1;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok[ENTRIES].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0 <= '0;
        end else begin
            r_tok0.valid <= w_accept;
            if (w_accept) begin
                r_tok0.cmd      <= i_command;
                r_tok0.found    <= 1'b0;
                r_tok0.carry.hi <= i_key_high;
                r_tok0.carry.lo <= i_key_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key.hi <= i_key_high;
            r_key.lo <= i_key_low;
            r_cmd    <= i_command;
            r_len    <= i_seg_length;
        end
        if (w_tok[ENTRIES].valid) begin
            r_found <= w_tok[ENTRIES].found;
        end
        if (w_load_out) begin
            r_hit   <= r_found && (r_cmd inside {CMD_CHECK, CMD_USE});
            r_bonus <= (r_found && (r_cmd == CMD_CHECK)) ? r_len : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_bonus     = r_bonus;

    // Only one beat may be in the chain at any time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_v))
        else $error("more than one token in the cell chain");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_tok[0].valid && (r_state == S_SCAN))
        else $error("accepted beat did not enter the chain");

    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[ENTRIES].valid |-> (r_state == S_SCAN))
        else $error("token left the chain outside a scan");

    a_bonus_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_bonus != 32'd0)) |-> o_hit)
        else $error("bonus reported without a hit");

endmodule

[rtl/mtfkc_cell.sv]
module mtfkc_cell
    import mtfkc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    input  t_key i_key,
    output t_tok o_tok
);

    t_key r_key;
    t_tok r_tok;
    logic w_match;
    logic w_shift;

    assign w_match = (r_key == i_key);

    // A use beat that has not yet met its key takes the carried key and
    // passes the displaced one on to the next cell.
    assign w_shift = i_tok.valid && (i_tok.cmd == CMD_USE) && !i_tok.found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (w_shift) begin
            r_key <= i_tok.carry;
        end else if (i_tok.valid && (i_tok.cmd == CMD_CLEAR)) begin
            r_key <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_tok.cmd   <= i_tok.cmd;
            r_tok.found <= i_tok.found | w_match;
            r_tok.carry <= w_shift ? r_key : i_tok.carry;
        end
    end

    assign o_tok = r_tok;

endmodule
